// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL module priority_ready_queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- rtl/prq_pkg.sv -----
// Types and constants of the priority ready queue.
package prq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [3:0] proc_id;
      logic [7:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] out_id;
      logic [7:0] out_priority;
      logic [4:0] occupancy;
   } rsp_type;

endpackage

// ----- rtl/priority_ready_queue.sv -----
// Sorted ready queue: highest priority first, arrival order among equals.
//
// Issue an insert or remove by raising start for one cycle; busy stays low, so an
// item may be issued every cycle. Its result appears on rsp_item with rsp_strobe
// high for one cycle, after the input register and then the result register; the
// receiver cannot stall it. The rate of one item per cycle is set by a row of
// priority comparators over all slots that finds the insert point and shifts the
// slot registers in a single step.
`include "assert_macros.svh"

module priority_ready_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  prq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output prq_pkg::rsp_type rsp_item
);

   logic                                  req_valid_ff;
   prq_pkg::req_type                      req_ff;
   logic [prq_pkg::CNT_BITS-1:0]          count_ff, count_in;
   logic [3:0]                            ids_ff   [prq_pkg::QUEUE_DEPTH];
   logic [3:0]                            ids_in   [prq_pkg::QUEUE_DEPTH];
   logic [prq_pkg::PRIORITY_BITS-1:0]     prios_ff [prq_pkg::QUEUE_DEPTH];
   logic [prq_pkg::PRIORITY_BITS-1:0]     prios_in [prq_pkg::QUEUE_DEPTH];
   logic [prq_pkg::QUEUE_DEPTH-1:0]       keep;
   logic [prq_pkg::PRIORITY_BITS-1:0]     new_prio;
   logic                                  rsp_strobe_ff;
   prq_pkg::rsp_type                      rsp_ff, rsp_in;
   logic                                  is_full, is_empty;

   assign busy     = 1'b0;
   assign new_prio = prq_pkg::PRIORITY_BITS'(req_ff.priority_req);
   assign is_full  = (count_ff == prq_pkg::CNT_BITS'(prq_pkg::QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // held entries at equal or higher priority stay in place (queue is sorted)
   always_comb begin
      for (int i = 0; i < prq_pkg::QUEUE_DEPTH; i++) begin
         keep[i] = (prq_pkg::CNT_BITS'(i) < count_ff) && (prios_ff[i] >= new_prio);
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      for (int i = 0; i < prq_pkg::QUEUE_DEPTH; i++) begin
         ids_in[i]   = ids_ff[i];
         prios_in[i] = prios_ff[i];
      end
      if (req_valid_ff) begin
         if (req_ff.kind == prq_pkg::KIND_INSERT) begin
            if (is_full) begin
               rsp_in.status = prq_pkg::STATUS_FULL;
            end else begin
               rsp_in.status = prq_pkg::STATUS_DONE;
               count_in      = count_ff + 1'b1;
               for (int i = 0; i < prq_pkg::QUEUE_DEPTH; i++) begin
                  if (keep[i]) begin
                     ids_in[i]   = ids_ff[i];
                     prios_in[i] = prios_ff[i];
                  end else if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                     ids_in[i]   = req_ff.proc_id;
                     prios_in[i] = new_prio;
                  end else begin
                     ids_in[i]   = ids_ff[(i == 0) ? 0 : i - 1];
                     prios_in[i] = prios_ff[(i == 0) ? 0 : i - 1];
                  end
               end
            end
         end else begin
            if (is_empty) begin
               rsp_in.status = prq_pkg::STATUS_EMPTY;
            end else begin
               rsp_in.status       = prq_pkg::STATUS_DONE;
               rsp_in.out_id       = ids_ff[0];
               rsp_in.out_priority = 8'(prios_ff[0]);
               count_in            = count_ff - 1'b1;
               for (int i = 0; i < prq_pkg::QUEUE_DEPTH - 1; i++) begin
                  ids_in[i]   = ids_ff[i + 1];
                  prios_in[i] = prios_ff[i + 1];
               end
            end
         end
         rsp_in.occupancy = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= req_valid_ff;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < prq_pkg::QUEUE_DEPTH; i++) begin
         ids_ff[i]   <= ids_in[i];
         prios_ff[i] <= prios_in[i];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `ASSERT_CLK(a_rsp_follows_transfer, start |=> ##1 rsp_strobe, "result strobe missing")
   `ASSERT_NEVER(a_count_bound, count_ff > prq_pkg::CNT_BITS'(prq_pkg::QUEUE_DEPTH), "count overflow")
   `ASSERT_CLK(a_full_occupancy, rsp_strobe && rsp_item.status == prq_pkg::STATUS_FULL |-> rsp_item.occupancy == 5'(prq_pkg::QUEUE_DEPTH), "full reported below depth")
   `ASSERT_CLK(a_insert_count, req_valid_ff && req_ff.kind == prq_pkg::KIND_INSERT && !is_full |=> count_ff == $past(count_ff) + 1'b1, "insert did not grow queue")

endmodule

// ----- verif/ready_queue_checker_pkg.sv -----
// Scoreboard class: sorted ready-queue predictor and result checker.
package ready_queue_checker_pkg;

   class ready_queue_checker;
      // Predicted queue contents, head at index 0
      logic [3:0]                        held_ids[$];
      logic [prq_pkg::PRIORITY_BITS-1:0] held_prios[$];
      prq_pkg::rsp_type                  expected_results[$];
      int                                mismatches;
      int                                transfers;
      int                                results;
      int                                full_inserts;
      int                                empty_removes;
      int                                peak_occupancy;

      function void log_mismatch(string msg);
         if (mismatches < 10) $display("mismatch: %s", msg);
         mismatches++;
      endfunction

      function prq_pkg::rsp_type predict(prq_pkg::req_type item);
         prq_pkg::rsp_type                  res;
         logic [prq_pkg::PRIORITY_BITS-1:0] prio;
         int                                pos;
         res  = '0;
         res.status = prq_pkg::STATUS_DONE;
         prio = prq_pkg::PRIORITY_BITS'(item.priority_req);
         if (item.kind == prq_pkg::KIND_INSERT) begin
            if (held_ids.size() >= prq_pkg::QUEUE_DEPTH) begin
               res.status = prq_pkg::STATUS_FULL;
               full_inserts++;
            end else begin
               // new entry goes behind every entry of equal or higher priority
               pos = 0;
               while (pos < held_ids.size() && held_prios[pos] >= prio) pos++;
               held_ids.insert(pos, item.proc_id);
               held_prios.insert(pos, prio);
            end
         end else begin
            if (held_ids.size() == 0) begin
               res.status = prq_pkg::STATUS_EMPTY;
               empty_removes++;
            end else begin
               res.out_id       = held_ids.pop_front();
               res.out_priority = 8'(held_prios.pop_front());
            end
         end
         res.occupancy = 5'(held_ids.size());
         if (held_ids.size() > peak_occupancy) peak_occupancy = held_ids.size();
         return res;
      endfunction

      function void note_transfer(prq_pkg::req_type item);
         expected_results.push_back(predict(item));
         transfers++;
      endfunction

      function void check_result(prq_pkg::rsp_type got);
         prq_pkg::rsp_type want;
         results++;
         if (expected_results.size() == 0) begin
            log_mismatch($sformatf("result with nothing expected: %p", got));
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
               log_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
            if (got.out_id !== want.out_id)
               log_mismatch($sformatf("out_id exp %0d got %0d", want.out_id, got.out_id));
            if (got.out_priority !== want.out_priority)
               log_mismatch($sformatf("out_priority exp %0d got %0d",
                                      want.out_priority, got.out_priority));
            if (got.occupancy !== want.occupancy)
               log_mismatch($sformatf("occupancy exp %0d got %0d",
                                      want.occupancy, got.occupancy));
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void flag_leftovers();
         foreach (expected_results[i])
            log_mismatch($sformatf("result never arrived: %p", expected_results[i]));
         expected_results.delete();
      endfunction
   endclass

endpackage

// ----- verif/priority_ready_queue_test.sv -----
// Top-level testbench of the priority ready queue.
module priority_ready_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   start = 1'b0;
   logic                                   busy;
   prq_pkg::req_type                       req_item = '0;
   logic                                   rsp_strobe;
   prq_pkg::rsp_type                       rsp_item;
   ready_queue_checker_pkg::ready_queue_checker tracker;
   int                                     cycle_count = 0;

   priority_ready_queue uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // Transfer and result monitor, sampled at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end else if (!reset) begin
         if (start && !busy) tracker.note_transfer(req_item);
         if (rsp_strobe) tracker.check_result(rsp_item);
      end
   end

   task automatic idle_cycle();
      @(negedge clock);
      start    <= 1'b0;
      req_item <= prq_pkg::req_type'($urandom);
   endtask

   task automatic send_item(input prq_pkg::req_type item);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic issue(input logic kind, input int id, input int prio);
      prq_pkg::req_type item;
      item.kind         = kind;
      item.proc_id      = 4'(id);
      item.priority_req = 8'(prio);
      send_item(item);
   endtask

   task automatic wait_drained();
      while (tracker.pending() != 0) idle_cycle();
   endtask

   // Segments alternate between filling, draining and balanced traffic, with
   // priority ranges that are wide, tie-heavy, or pinned at either extreme.
   task automatic run_phase(input int n_items, input int idle_pct, input int pause_at);
      prq_pkg::req_type item;
      int               insert_pct;
      int               lo;
      int               hi;
      int               seg_left;
      seg_left   = 0;
      insert_pct = 50;
      lo         = 0;
      hi         = 255;
      for (int i = 0; i < n_items; i++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(40, 10);
            case ($urandom_range(2))
               0: insert_pct = 75;
               1: insert_pct = 25;
               default: insert_pct = 52;
            endcase
            case ($urandom_range(3))
               0: begin
                  lo = 0;
                  hi = 255;
               end
               1: begin
                  lo = $urandom_range(252);
                  hi = lo + 3;
               end
               2: begin
                  lo = 0;
                  hi = 3;
               end
               default: begin
                  lo = 252;
                  hi = 255;
               end
            endcase
         end
         seg_left--;
         item.kind         = ($urandom_range(99) < insert_pct) ?
                             prq_pkg::KIND_INSERT : prq_pkg::KIND_REMOVE;
         item.proc_id      = 4'($urandom_range(15));
         item.priority_req = 8'($urandom_range(hi, lo));
         while ($urandom_range(99) < idle_pct) idle_cycle();
         if (i == pause_at) wait_drained();
         send_item(item);
      end
   endtask

   initial begin
      tracker = new;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty removes, ignored fields set on one of them
      issue(prq_pkg::KIND_REMOVE, 15, 255);
      issue(prq_pkg::KIND_REMOVE, 0, 0);
      // fill to the brim: extremes and ties at both ends
      issue(prq_pkg::KIND_INSERT, 3, 128);
      issue(prq_pkg::KIND_INSERT, 15, 255);
      issue(prq_pkg::KIND_INSERT, 0, 0);
      issue(prq_pkg::KIND_INSERT, 7, 255);
      issue(prq_pkg::KIND_INSERT, 9, 128);
      issue(prq_pkg::KIND_INSERT, 1, 0);
      for (int i = 0; i < 10; i++) issue(prq_pkg::KIND_INSERT, i + 2, (i * 37) & 8'hff);
      // full: dropped
      issue(prq_pkg::KIND_INSERT, 2, 200);
      repeat (4) issue(prq_pkg::KIND_REMOVE, 0, 0);

      idle_cycle();
      wait_drained();
      run_phase(470, 0, 235);
      run_phase(460, 88, -1);
      run_phase(460, 26, 100);
      run_phase(460, 0, -1);

      idle_cycle();
      wait_drained();
      repeat (DRAIN_CYCLES) idle_cycle();
      tracker.flag_leftovers();

      $display("%0d transfers, %0d results checked; %0d inserts on a full queue,",
               tracker.transfers, tracker.results, tracker.full_inserts);
      $display("%0d removes on an empty queue, peak occupancy %0d; %0d mismatches",
               tracker.empty_removes, tracker.peak_occupancy, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
